// File: rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants for the string delimiter splitter
// Result kinds, register indexes and register reset values.
// ----------------------------------------------------------------------------
package sds_pkg;

   // Result kind carried on every output beat
   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_TOKEN_END  = 2'd1,
      KIND_STRING_END = 2'd2
   } kind_type;

   // Register map
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIM_LEN   = 2'd0,
      CSR_DELIM_BYTES = 2'd1
   } csr_index_type;

   localparam int DELIM_LEN_W   = 4;
   localparam int DELIM_BYTES_W = 64;

   localparam logic [DELIM_LEN_W-1:0]   RESET_DELIM_LEN   = 4'd1;
   localparam logic [DELIM_BYTES_W-1:0] RESET_DELIM_BYTES = 64'd44;

endpackage

// File: rtl/sds_if.sv
// ----------------------------------------------------------------------------
// sds_if: channel interfaces of the string delimiter splitter
// Request bytes, result beats and register writes, each with valid/ready.
// ----------------------------------------------------------------------------
interface sds_req_if
   import sds_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_string;

   modport source (output valid, output char_byte, output end_of_string, input ready);
   modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface sds_rsp_if
   import sds_pkg::*;
   ();
   logic       valid;
   logic       ready;
   kind_type   kind;
   logic [7:0] token_byte;
   logic       last_of_run;

   modport source (output valid, output kind, output token_byte, output last_of_run,
                   input ready);
   modport sink   (input valid, input kind, input token_byte, input last_of_run,
                   output ready);
endinterface

interface sds_csr_if
   import sds_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/string_delimiter_splitter.sv
// ----------------------------------------------------------------------------
// string_delimiter_splitter: streaming tokenizer on a multi-byte delimiter
// Splits a byte stream on a programmable delimiter of up to MAX_DELIM bytes.
// ----------------------------------------------------------------------------
// Usage
//   req_bus carries one string byte per beat; a beat with end_of_string set
//   terminates the string. rsp_bus carries token bytes, end-of-token and
//   end-of-string beats; last_of_run flags the final beat caused by a request.
//   csr_bus writes delimiter_length (index 0) and delimiter_bytes (index 1),
//   always ready; write only while the block is idle.
// Timing
//   A request beat's first result is registered in the cycle after the beat.
//   Byte beats are taken one per cycle while the output register is free and
//   no flush is running. A terminator drains each pending window byte, then
//   closes an open token, then emits the end-of-string beat; req_bus.ready
//   stays low while the window drains through the single output register.
// Reset
//   Synchronous: empties the window, closes the token, drops any pending
//   result, and restores a one-byte comma delimiter.
// Backpressure
//   With rsp_bus.ready low the output register holds its beat and req_bus
//   stalls; a new request is taken in the same cycle the held beat leaves.
// ----------------------------------------------------------------------------
module string_delimiter_splitter
   import sds_pkg::*;
#(
   parameter int MAX_DELIM = 8
) (
   input  logic      clock,
   input  logic      reset,
   sds_req_if.sink   req_bus,
   sds_rsp_if.source rsp_bus,
   sds_csr_if.sink   csr_bus
);

   localparam int CntW = $clog2(MAX_DELIM + 1);
   localparam int WinW = 8 * MAX_DELIM;

   // Configuration
   logic [DELIM_LEN_W-1:0]   delim_len_ff, delim_len_in;
   logic [DELIM_BYTES_W-1:0] delim_bytes_ff, delim_bytes_in;

   // Window and token state
   logic [WinW-1:0] win_ff, win_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            open_ff, open_in;
   logic            flush_ff, flush_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic            out_free;
   logic            req_acc;
   logic [CntW-1:0] eff_len;
   logic [WinW-1:0] delim_pad;
   logic [WinW-1:0] win_app;
   logic [CntW-1:0] fill_app;
   logic            match;

   // Pad delimiter bytes out to the window width; bytes past 64 bits read zero
   generate
      if (WinW <= DELIM_BYTES_W) begin : g_delim_cut
         assign delim_pad = delim_bytes_ff[WinW-1:0];
      end else begin : g_delim_ext
         assign delim_pad = {{(WinW - DELIM_BYTES_W){1'b0}}, delim_bytes_ff};
      end
   endgenerate

   // Clamp the programmed length into 1..MAX_DELIM
   always_comb begin
      if (delim_len_ff == '0) begin
         eff_len = CntW'(1);
      end else if (32'(delim_len_ff) > MAX_DELIM) begin
         eff_len = CntW'(MAX_DELIM);
      end else begin
         eff_len = CntW'(delim_len_ff);
      end
   end

   // Append the incoming byte at the fill point
   always_comb begin
      win_app  = win_ff;
      fill_app = fill_ff;
      if (fill_ff < CntW'(MAX_DELIM)) begin
         for (int i = 0; i < MAX_DELIM; i++) begin
            if (fill_ff == CntW'(i)) begin
               win_app[8*i +: 8] = req_bus.char_byte;
            end
         end
         fill_app = fill_ff + CntW'(1);
      end
   end

   // Compare the leading eff_len window bytes with the delimiter
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < MAX_DELIM; i++) begin
         if (CntW'(i) < eff_len && win_app[8*i +: 8] != delim_pad[8*i +: 8]) begin
            match = 1'b0;
         end
      end
   end

   // Handshakes
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = out_free && !flush_ff;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Next-state logic for one byte decision or one flush beat
   always_comb begin
      delim_len_in   = delim_len_ff;
      delim_bytes_in = delim_bytes_ff;
      win_in         = win_ff;
      fill_in        = fill_ff;
      open_in        = open_ff;
      flush_in       = flush_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;

      // register writes
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_DELIM_LEN:   delim_len_in   = csr_bus.data[DELIM_LEN_W-1:0];
            CSR_DELIM_BYTES: delim_bytes_in = csr_bus.data[DELIM_BYTES_W-1:0];
            default: ;
         endcase
      end

      if ((flush_ff && out_free) || (req_acc && req_bus.end_of_string)) begin
         // drain one pending byte, then close the token, then end the string
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b0;
         rsp_byte_in  = 8'd0;
         flush_in     = 1'b1;
         if (fill_ff != '0) begin
            rsp_kind_in = KIND_BYTE;
            rsp_byte_in = win_ff[7:0];
            win_in      = win_ff >> 8;
            fill_in     = fill_ff - CntW'(1);
            open_in     = 1'b1;
         end else if (open_ff) begin
            rsp_kind_in = KIND_TOKEN_END;
            open_in     = 1'b0;
         end else begin
            rsp_kind_in = KIND_STRING_END;
            rsp_last_in = 1'b1;
            flush_in    = 1'b0;
         end
      end else if (req_acc) begin
         win_in  = win_app;
         fill_in = fill_app;
         if (fill_app >= eff_len) begin
            if (match) begin
               // discard the delimiter and close an open token
               if (eff_len >= fill_app) begin
                  fill_in = '0;
               end else begin
                  win_in  = win_app >> {eff_len, 3'b000};
                  fill_in = fill_app - eff_len;
               end
               if (open_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_TOKEN_END;
                  rsp_byte_in  = 8'd0;
                  rsp_last_in  = 1'b1;
                  open_in      = 1'b0;
               end
            end else begin
               // release the oldest byte as a token byte
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_BYTE;
               rsp_byte_in  = win_app[7:0];
               rsp_last_in  = 1'b1;
               win_in       = win_app >> 8;
               fill_in      = fill_app - CntW'(1);
               open_in      = 1'b1;
            end
         end
      end
   end

   // State and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_len_ff   <= RESET_DELIM_LEN;
         delim_bytes_ff <= RESET_DELIM_BYTES;
         fill_ff        <= '0;
         open_ff        <= 1'b0;
         flush_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         delim_len_ff   <= delim_len_in;
         delim_bytes_ff <= delim_bytes_in;
         fill_ff        <= fill_in;
         open_ff        <= open_in;
         flush_ff       <= flush_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      win_ff      <= win_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.token_byte  = rsp_byte_ff;
   assign rsp_bus.last_of_run = rsp_last_ff;

endmodule

// File: rtl/sds_checker.sv
// ----------------------------------------------------------------------------
// sds_checker: port-level checks for the string delimiter splitter
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sds_checker
   import sds_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input kind_type   rsp_kind,
   input logic [7:0] rsp_token_byte,
   input logic       rsp_last_of_run
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_token_byte) && $stable(rsp_last_of_run))
      else $error("sds: stalled result beat changed");

   // Marker beats carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_BYTE |-> rsp_token_byte == 8'd0)
      else $error("sds: marker beat with nonzero byte");

   // End of string always closes the run of its terminator
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STRING_END |-> rsp_last_of_run)
      else $error("sds: end of string without last_of_run");

   // A delivered end of string is never followed directly by an end of token
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_STRING_END ##1 rsp_valid
         |-> rsp_kind != KIND_TOKEN_END)
      else $error("sds: token closed after end of string");

endmodule

bind string_delimiter_splitter sds_checker u_sds_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_token_byte  (rsp_bus.token_byte),
   .rsp_last_of_run (rsp_bus.last_of_run)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the string delimiter splitter
// Sends byte strings and terminators with random gaps while the result side
// stalls at random. A scoreboard predicts every result beat from the
// delimiter registers and checks each one in order.
// ----------------------------------------------------------------------------
module testbench;
   import sds_pkg::*;

   localparam int MAX_DELIM    = 8;
   localparam int DRAIN_CYCLES = MAX_DELIM + 4;
   localparam int MAX_SHOWN    = 40;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 40;

   typedef struct {
      kind_type   kind;
      logic [7:0] token_byte;
      logic       last_of_run;
   } split_beat_type;

   // Predicts the splitter's output beats and checks the observed ones
   class split_scoreboard;
      split_beat_type           expected_beats[$];
      logic [DELIM_LEN_W-1:0]   delim_len;
      logic [DELIM_BYTES_W-1:0] delim_bytes;
      logic [7:0]               window[MAX_DELIM];
      int unsigned              fill;
      bit                       token_open;
      int unsigned              errors;

      function new();
         delim_len   = RESET_DELIM_LEN;
         delim_bytes = RESET_DELIM_BYTES;
         fill        = 0;
         token_open  = 0;
         errors      = 0;
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DELIM_LEN:   delim_len = data[DELIM_LEN_W-1:0];
            CSR_DELIM_BYTES: delim_bytes = data;
            default: ;
         endcase
      endfunction

      function void push_beat(kind_type k, logic [7:0] b);
         split_beat_type e;
         e.kind        = k;
         e.token_byte  = b;
         e.last_of_run = 1'b0;
         expected_beats.push_back(e);
      endfunction

      // Drop the n oldest pending bytes
      function void shift_out(int unsigned n);
         int unsigned i;
         if (n >= fill) begin
            fill = 0;
            return;
         end
         for (i = 0; i + n < fill; i++) window[i] = window[i + n];
         fill -= n;
      endfunction

      function void take_request(logic [7:0] ch, logic eos);
         int unsigned eff;
         int unsigned first;
         bit          hit;
         eff = 32'(delim_len);
         if (eff == 0) eff = 1;
         if (eff > MAX_DELIM) eff = MAX_DELIM;
         first = expected_beats.size();
         if (eos) begin
            // Flush the window, close the token, mark the end of string
            for (int unsigned i = 0; i < fill; i++) begin
               push_beat(KIND_BYTE, window[i]);
               token_open = 1;
            end
            fill = 0;
            if (token_open) push_beat(KIND_TOKEN_END, 8'h00);
            token_open = 0;
            push_beat(KIND_STRING_END, 8'h00);
         end else begin
            if (fill < MAX_DELIM) begin
               window[fill] = ch;
               fill++;
            end
            // Decide once a full window is present
            if (fill >= eff) begin
               hit = 1;
               for (int unsigned i = 0; i < eff; i++)
                  if (window[i] != delim_bytes[8*i +: 8]) hit = 0;
               if (hit) begin
                  shift_out(eff);
                  if (token_open) begin
                     push_beat(KIND_TOKEN_END, 8'h00);
                     token_open = 0;
                  end
               end else begin
                  push_beat(KIND_BYTE, window[0]);
                  token_open = 1;
                  shift_out(1);
               end
            end
         end
         if (expected_beats.size() > first)
            expected_beats[expected_beats.size() - 1].last_of_run = 1'b1;
      endfunction

      task check_beat(kind_type k, logic [7:0] b, logic last);
         split_beat_type e;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d byte %02h last %0b",
                                      k, b, last));
            return;
         end
         e = expected_beats.pop_front();
         if (k !== e.kind || b !== e.token_byte || last !== e.last_of_run)
            report_mismatch($sformatf(
               "got kind %0d byte %02h last %0b, want kind %0d byte %02h last %0b",
               k, b, last, e.kind, e.token_byte, e.last_of_run));
      endtask
   endclass

   logic            clock;
   logic            reset;
   split_scoreboard board;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   logic [3:0]      phase_len[PHASES];

   sds_req_if req_bus ();
   sds_rsp_if rsp_bus ();
   sds_csr_if csr_bus ();

   string_delimiter_splitter #(
      .MAX_DELIM(MAX_DELIM)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: stall at random, change ready on the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_beat(rsp_bus.kind, rsp_bus.token_byte, rsp_bus.last_of_run);
   end

   // Send one request beat; starts and ends just after a falling edge
   task send_item(logic [7:0] ch, logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid         = 1'b1;
      req_bus.char_byte     = ch;
      req_bus.end_of_string = eos;
      do @(posedge clock); while (!req_bus.ready);
      board.take_request(ch, eos);
      @(negedge clock);
   endtask

   task send_text(string s, bit terminate);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
      if (terminate) send_item(8'($urandom), 1'b1);
   endtask

   // Hold off the sender until every predicted beat has come out
   task wait_drained();
      req_bus.valid = 1'b0;
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_register(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // One random phase: program the delimiter, then mostly well-formed strings
   task run_phase(logic [3:0] len_code, int budget);
      int              eff;
      int              left;
      int              k;
      int              plen;
      logic [63:0]     data;
      logic [63:0]     dbytes;
      logic [7:0]      sym_x;
      logic [7:0]      sym_y;
      logic [7:0]      text[$];
      wait_drained();
      data      = {$urandom, $urandom};
      data[3:0] = len_code;
      write_csr(CSR_DELIM_LEN, data);
      sym_x = 8'($urandom);
      sym_y = 8'($urandom);
      if ($urandom_range(1)) begin
         dbytes = {$urandom, $urandom};
      end else begin
         for (k = 0; k < 8; k++) dbytes[8*k +: 8] = $urandom_range(1) ? sym_x : sym_y;
      end
      write_csr(CSR_DELIM_BYTES, dbytes);
      eff = (len_code == 0) ? 1 : (len_code > MAX_DELIM) ? MAX_DELIM : len_code;
      left = budget;
      while (left > 0) begin
         text.delete();
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(12)) text.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(3)) begin
               // token content, then a full or partial delimiter
               repeat ($urandom_range(4)) begin
                  case ($urandom_range(2))
                     0: begin
                        k = $urandom_range(eff - 1);
                        text.push_back(dbytes[8*k +: 8]);
                     end
                     1: text.push_back($urandom_range(1) ? sym_x : sym_y);
                     default: text.push_back(8'($urandom));
                  endcase
               end
               plen = ($urandom_range(99) < 70) ? eff : $urandom_range(eff - 1);
               for (k = 0; k < plen; k++) text.push_back(dbytes[8*k +: 8]);
            end
         end
         for (int i = 0; i < text.size() && left > 0; i++) begin
            send_item(text[i], 1'b0);
            left--;
         end
         if (left > 0) begin
            send_item(8'($urandom), 1'b1);
            left--;
         end
         if ($urandom_range(29) == 0) wait_drained();
      end
   endtask

   initial begin
      board     = new();
      phase_len = '{4'd1, 4'd8, 4'd2, 4'd3, 4'd0, 4'd15, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1};
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.char_byte     = 8'h00;
      req_bus.end_of_string = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_DELIM_LEN;
      csr_bus.data          = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset delimiter: empty tokens between commas, empty string, byte extremes
      send_text("a,,b", 1'b1);
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'($urandom), 1'b1);

      // Zero length acts as one byte
      wait_drained();
      write_csr(CSR_DELIM_LEN, 64'h0);
      write_csr(CSR_DELIM_BYTES, 64'h0);
      send_item(8'h00, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'($urandom), 1'b1);

      // Oversized length saturates; terminator flushes a partial window
      wait_drained();
      write_csr(CSR_DELIM_LEN, 64'hF);
      write_csr(CSR_DELIM_BYTES, '1);
      repeat (3) send_item(8'hFF, 1'b0);
      send_item(8'($urandom), 1'b1);

      // Shorten the delimiter while bytes are pending in the window
      wait_drained();
      write_csr(CSR_DELIM_LEN, 64'h4);
      write_csr(CSR_DELIM_BYTES, 64'h6463_6261);
      send_text("abx", 1'b0);
      wait_drained();
      write_csr(CSR_DELIM_LEN, 64'h1);
      write_csr(CSR_DELIM_BYTES, 64'd44);
      send_text("y", 1'b1);

      // Random phases, rotating through the idling patterns
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         run_phase(phase_len[p], PHASE_ITEMS);
      end

      // Close any open string and let everything drain
      wait_drained();
      send_item(8'($urandom), 1'b1);
      wait_drained();

      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
